// ===== src/stm_pkg.sv =====
// shared types and constants for the single-touch to multitouch translator
// no dependencies; imported by every module under src
`default_nettype none

package stm_pkg;

  localparam logic [15:0] KIND_SYN        = 16'h0000;
  localparam logic [15:0] KIND_KEY        = 16'h0001;
  localparam logic [15:0] KIND_ABS        = 16'h0003;
  localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
  localparam logic [15:0] CODE_TRACK_ID   = 16'h0039;
  localparam logic [15:0] CODE_POS_X      = 16'h0035;
  localparam logic [15:0] CODE_POS_Y      = 16'h0036;
  localparam logic [15:0] CODE_MAJOR      = 16'h0030;
  localparam logic [15:0] CODE_BTN_TOUCH  = 16'h014a;

  localparam logic signed [31:0] MAJOR_DOWN = 32'sd100;
  localparam logic signed [31:0] MAJOR_UP   = 32'sd0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [31:0]        stamp_sec;
    logic [31:0]        stamp_usec;
    logic [15:0]        ev_kind;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        out_sec;
    logic [31:0]        out_usec;
    logic [15:0]        out_kind;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        sec;
    logic [31:0]        usec;
    logic signed [31:0] contact_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               down;
  } frame_t;

  typedef enum logic [2:0] {
    BEAT_ID,
    BEAT_X,
    BEAT_Y,
    BEAT_MAJOR,
    BEAT_SYN
  } beat_t;

endpackage

`default_nettype wire

// ===== src/single_touch_to_multitouch_events.sv =====
// single-touch to multitouch event translator, top level
// uses stm_pkg, stm_front, stm_fifo, stm_back
//
// input channel in_valid/in_ready/in_data carries raw events (time, type, code, value);
// output channel out_valid/out_ready/out_data carries translated events.
// abs events update tracking id (non-negative only), x and y; the touch key sets a
// pending flag. a sync report while pressed, held or released queues one frame of
// five events: tracking id, x, y, touch major (100 or 0) and a sync report marked
// with out_last. other events produce nothing.
// an input event is taken every cycle while the four-frame queue has room; the
// output port sends one event per cycle while out_ready is high, so a stream of
// reports is limited by the output side, which sends each frame as five events.
// a frame's first event is valid once the queue, then the back end, has registered it.
// when the receiver stalls, the current event holds and frames pile up in the
// queue; in_ready drops only once the queue is full. reset clears the contact
// state and empties the queue.
`default_nettype none

module single_touch_to_multitouch_events (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stm_pkg::out_item_t      out_data
);
  import stm_pkg::*;

  frame_t wr_frame;
  frame_t rd_frame;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  stm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .frame    (wr_frame)
  );

  stm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_frame),
    .pop     (pop),
    .rd_data (rd_frame),
    .full    (full),
    .empty   (empty)
  );

  stm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .rd_data   (rd_frame),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/stm_front.sv =====
// front end: accepts raw events, tracks contact, queues a frame per touch report
// depends on stm_pkg
`default_nettype none

module stm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stm_pkg::in_item_t in_data,
  input  wire logic              full,
  output logic                   push,
  output stm_pkg::frame_t        frame
);
  import stm_pkg::*;

  logic signed [31:0] contact_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               touch_pending;
  logic               contact_down;
  logic               accept;
  logic               is_report;

  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;
  assign is_report = (in_data.ev_kind == KIND_SYN) && (in_data.ev_code == CODE_SYN_REPORT);
  assign push      = accept && is_report && (touch_pending || contact_down);

  always_comb begin
    frame.sec        = in_data.stamp_sec;
    frame.usec       = in_data.stamp_usec;
    frame.contact_id = contact_id;
    frame.pos_x      = pos_x;
    frame.pos_y      = pos_y;
    frame.down       = touch_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_id    <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      touch_pending <= 1'b0;
      contact_down  <= 1'b0;
    end else if (accept) begin
      if (in_data.ev_kind == KIND_ABS) begin
        if (in_data.ev_code == CODE_TRACK_ID && !in_data.ev_value[31]) begin
          contact_id <= in_data.ev_value;
        end else if (in_data.ev_code == CODE_POS_X) begin
          pos_x <= in_data.ev_value;
        end else if (in_data.ev_code == CODE_POS_Y) begin
          pos_y <= in_data.ev_value;
        end
      end else if (in_data.ev_kind == KIND_KEY) begin
        if (in_data.ev_code == CODE_BTN_TOUCH) begin
          touch_pending <= (in_data.ev_value != 32'sd0);
        end
      end else if (is_report) begin
        contact_down <= touch_pending;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/stm_fifo.sv =====
// short frame queue between front and back ends
// depends on stm_pkg
`default_nettype none

module stm_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire stm_pkg::frame_t wr_data,
  input  wire logic            pop,
  output stm_pkg::frame_t      rd_data,
  output logic                 full,
  output logic                 empty
);
  import stm_pkg::*;

  frame_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full    = (count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full frame queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty frame queue");
  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    count[FIFO_AW-1:0] == FIFO_AW'(wr_ptr - rd_ptr))
    else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ===== src/stm_back.sv =====
// back end: plays one queued frame out as five multitouch events
// depends on stm_pkg
`default_nettype none

module stm_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire stm_pkg::frame_t rd_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output stm_pkg::out_item_t   out_data
);
  import stm_pkg::*;

  frame_t cur;
  logic   busy;
  logic   busy_next;
  beat_t  beat;
  beat_t  beat_next;
  logic   advance;
  logic   done;

  assign out_valid = busy;
  assign advance   = out_valid && out_ready;
  assign done      = !busy || (advance && beat == BEAT_SYN);
  assign pop       = done && !empty;
  assign busy_next = done ? !empty : busy;

  always_comb begin
    beat_next = beat;
    if (pop) begin
      beat_next = BEAT_ID;
    end else if (advance) begin
      unique case (beat)
        BEAT_ID:    beat_next = BEAT_X;
        BEAT_X:     beat_next = BEAT_Y;
        BEAT_Y:     beat_next = BEAT_MAJOR;
        BEAT_MAJOR: beat_next = BEAT_SYN;
        BEAT_SYN:   beat_next = BEAT_ID;
        default:    beat_next = BEAT_ID;
      endcase
    end
  end

  always_comb begin
    out_data.out_sec  = cur.sec;
    out_data.out_usec = cur.usec;
    out_data.out_last = 1'b0;
    out_data.out_kind = KIND_ABS;
    unique case (beat)
      BEAT_ID: begin
        out_data.out_code  = CODE_TRACK_ID;
        out_data.out_value = cur.contact_id;
      end
      BEAT_X: begin
        out_data.out_code  = CODE_POS_X;
        out_data.out_value = cur.pos_x;
      end
      BEAT_Y: begin
        out_data.out_code  = CODE_POS_Y;
        out_data.out_value = cur.pos_y;
      end
      BEAT_MAJOR: begin
        out_data.out_code  = CODE_MAJOR;
        out_data.out_value = cur.down ? MAJOR_DOWN : MAJOR_UP;
      end
      BEAT_SYN: begin
        out_data.out_kind  = KIND_SYN;
        out_data.out_code  = CODE_SYN_REPORT;
        out_data.out_value = 32'sd0;
        out_data.out_last  = 1'b1;
      end
      default: begin
        out_data.out_code  = CODE_SYN_REPORT;
        out_data.out_value = 32'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= BEAT_ID;
    end else begin
      busy <= busy_next;
      beat <= beat_next;
    end
  end

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    advance && beat != BEAT_SYN |=> out_valid && $stable(cur))
    else $error("frame changed before its sync event went out");
  a_id_then_x: assert property (@(posedge clk) disable iff (rst)
    advance && beat == BEAT_ID |=> beat == BEAT_X)
    else $error("beat order broken after tracking id");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !busy || (out_ready && beat == BEAT_SYN))
    else $error("frame popped while another is still going out");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for single_touch_to_multitouch_events
// predicts the multitouch frames of each raw event and checks every output event
// depends on stm_pkg and the rtl under src
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stm_pkg::*;

  localparam int          STALL_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam logic [15:0] CODE_MT_REPORT = 16'h0002;
  localparam logic [15:0] KIND_UNKNOWN   = 16'h0002;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // predicted contact state
  logic signed [31:0] trk_id = '0;
  logic signed [31:0] cur_x = '0;
  logic signed [31:0] cur_y = '0;
  logic               touch_held = 1'b0;
  logic               contact_on = 1'b0;

  out_item_t outbound_events[$];
  int err_count = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  single_touch_to_multitouch_events i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic out_item_t make_event(logic [31:0] sec, logic [31:0] usec,
                                           logic [15:0] kind, logic [15:0] code,
                                           logic signed [31:0] value, logic last);
    out_item_t ev;
    ev.out_sec   = sec;
    ev.out_usec  = usec;
    ev.out_kind  = kind;
    ev.out_code  = code;
    ev.out_value = value;
    ev.out_last  = last;
    return ev;
  endfunction

  task automatic translate_event(input in_item_t ev);
    logic signed [31:0] major;
    case (ev.ev_kind)
      KIND_ABS: begin
        if (ev.ev_code == CODE_TRACK_ID && !ev.ev_value[31]) trk_id = ev.ev_value;
        else if (ev.ev_code == CODE_POS_X) cur_x = ev.ev_value;
        else if (ev.ev_code == CODE_POS_Y) cur_y = ev.ev_value;
      end
      KIND_KEY: begin
        if (ev.ev_code == CODE_BTN_TOUCH) touch_held = (ev.ev_value != 0);
      end
      KIND_SYN: begin
        if (ev.ev_code == CODE_SYN_REPORT && (touch_held || contact_on)) begin
          major = touch_held ? MAJOR_DOWN : MAJOR_UP;
          contact_on = touch_held;
          outbound_events.push_back(make_event(ev.stamp_sec, ev.stamp_usec, KIND_ABS,
                                               CODE_TRACK_ID, trk_id, 1'b0));
          outbound_events.push_back(make_event(ev.stamp_sec, ev.stamp_usec, KIND_ABS,
                                               CODE_POS_X, cur_x, 1'b0));
          outbound_events.push_back(make_event(ev.stamp_sec, ev.stamp_usec, KIND_ABS,
                                               CODE_POS_Y, cur_y, 1'b0));
          outbound_events.push_back(make_event(ev.stamp_sec, ev.stamp_usec, KIND_ABS,
                                               CODE_MAJOR, major, 1'b0));
          outbound_events.push_back(make_event(ev.stamp_sec, ev.stamp_usec, KIND_SYN,
                                               CODE_SYN_REPORT, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endtask

  // outputs are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (outbound_events.size() == 0) begin
          err_count++;
          $error("unexpected output event: %p", out_data);
        end else begin
          want = outbound_events.pop_front();
          check_field("out_sec", want.out_sec, out_data.out_sec);
          check_field("out_usec", want.out_usec, out_data.out_usec);
          check_field("out_kind", 32'(want.out_kind), 32'(out_data.out_kind));
          check_field("out_code", 32'(want.out_code), 32'(out_data.out_code));
          check_field("out_value", want.out_value, out_data.out_value);
          check_field("out_last", 32'(want.out_last), 32'(out_data.out_last));
        end
      end
      if (in_valid && in_ready) translate_event(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_stamped(input logic [31:0] sec, input logic [31:0] usec,
                              input logic [15:0] kind, input logic [15:0] code,
                              input logic signed [31:0] value);
    in_item_t req;
    req.stamp_sec  = sec;
    req.stamp_usec = usec;
    req.ev_kind    = kind;
    req.ev_code    = code;
    req.ev_value   = value;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_event(input logic [15:0] kind, input logic [15:0] code,
                            input logic signed [31:0] value);
    send_stamped($urandom, $urandom, kind, code, value);
  endtask

  // sender holds off until every frame has drained
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outbound_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_ignored_events();
    send_stamped('0, '0, KIND_SYN, CODE_SYN_REPORT, 32'sd0);
    send_event(KIND_ABS, CODE_TRACK_ID, 32'sh8000_0000);
    send_event(KIND_ABS, 16'hffff, 32'sd5);
    send_event(KIND_ABS, CODE_MAJOR, 32'sh7fff_ffff);
    send_event(KIND_KEY, 16'h014b, 32'sd1);
    send_event(16'hffff, CODE_SYN_REPORT, 32'sd1);
    send_event(KIND_UNKNOWN, CODE_BTN_TOUCH, -32'sd1);
    send_event(KIND_SYN, CODE_MT_REPORT, 32'sd0);
  endtask

  task automatic test_touch_frames();
    // press, hold with a negative id, release, idle report, then press and release
    send_event(KIND_ABS, CODE_TRACK_ID, 32'sh7fff_ffff);
    send_event(KIND_ABS, CODE_POS_X, 32'sh8000_0000);
    send_event(KIND_ABS, CODE_POS_Y, 32'sh7fff_ffff);
    send_event(KIND_KEY, CODE_BTN_TOUCH, -32'sd1);
    send_stamped(32'hffff_ffff, 32'hffff_ffff, KIND_SYN, CODE_SYN_REPORT, 32'sd0);
    send_event(KIND_ABS, CODE_TRACK_ID, -32'sd5);
    send_event(KIND_ABS, CODE_POS_X, 32'sd0);
    send_event(KIND_ABS, CODE_POS_Y, -32'sd1);
    send_event(KIND_SYN, CODE_MT_REPORT, 32'sd0);
    send_event(KIND_SYN, CODE_SYN_REPORT, -32'sd1);
    send_event(KIND_KEY, CODE_BTN_TOUCH, 32'sd0);
    send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0);
    send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0);
    send_event(KIND_ABS, CODE_TRACK_ID, 32'sd0);
    send_event(KIND_KEY, CODE_BTN_TOUCH, 32'sh8000_0000);
    send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0);
    send_event(KIND_KEY, CODE_BTN_TOUCH, 32'sd0);
    send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0);
  endtask

  task automatic send_noise();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: send_event(16'($urandom), 16'($urandom), v);
      1: send_event(KIND_SYN, $urandom_range(1) ? CODE_SYN_REPORT : 16'($urandom), v);
      2: send_event(KIND_KEY, $urandom_range(3) ? CODE_BTN_TOUCH : 16'($urandom), v);
      default: begin
        case ($urandom_range(3))
          0: send_event(KIND_ABS, CODE_TRACK_ID, v);
          1: send_event(KIND_ABS, CODE_POS_X, v);
          2: send_event(KIND_ABS, CODE_POS_Y, v);
          default: send_event(KIND_ABS, 16'($urandom), v);
        endcase
      end
    endcase
  endtask

  task automatic send_gesture();
    logic signed [31:0] v;
    int moves;
    v = $urandom;
    if (v == 0) v = 32'sd1;
    send_event(KIND_KEY, CODE_BTN_TOUCH, v);
    if ($urandom_range(9) != 0) begin
      v = $urandom;
      if ($urandom_range(4) != 0) v[31] = 1'b0;
      send_event(KIND_ABS, CODE_TRACK_ID, v);
    end
    moves = $urandom_range(1, 4);
    repeat (moves) begin
      if ($urandom_range(4) != 0) send_event(KIND_ABS, CODE_POS_X, $urandom);
      if ($urandom_range(4) != 0) send_event(KIND_ABS, CODE_POS_Y, $urandom);
      if ($urandom_range(9) == 0) send_noise();
      send_event(KIND_SYN, CODE_SYN_REPORT, $urandom);
    end
    send_event(KIND_KEY, CODE_BTN_TOUCH, 32'sd0);
    if ($urandom_range(9) != 0) send_event(KIND_SYN, CODE_SYN_REPORT, $urandom);
  endtask

  task automatic test_random_gestures(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) send_gesture();
      else send_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct = 62;
    test_ignored_events();
    test_touch_frames();
    wait_for_quiet();
    test_random_gestures(80);
    wait_for_quiet();

    send_idle_pct = 62;
    recv_idle_pct = 21;
    test_random_gestures(80);
    wait_for_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_gestures(80);
    wait_for_quiet();

    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
